FILE: hw/rtl/fcsb_pkg.sv
// ----------------------------------------------------------------------------
// fcsb_pkg
// Shared types and codes for the sphere/box frustum culling block.
// ----------------------------------------------------------------------------
package fcsb_pkg;

   localparam int COORD_W = 32;
   localparam int RADIUS_W = 31;

   // command codes
   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_SPHERE = 2'd1;
   localparam logic [1:0] CMD_BOX    = 2'd2;

   // coefficient position within a plane
   localparam logic [1:0] COEF_A = 2'd0;
   localparam logic [1:0] COEF_B = 2'd1;
   localparam logic [1:0] COEF_C = 2'd2;
   localparam logic [1:0] COEF_D = 2'd3;

   // verdict codes
   localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
   localparam logic [1:0] VERDICT_PARTLY  = 2'd1;
   localparam logic [1:0] VERDICT_INSIDE  = 2'd2;
   localparam logic [1:0] VERDICT_CULLED  = 2'd0;
   localparam logic [1:0] VERDICT_VISIBLE = 2'd1;

   typedef struct packed {
      logic [1:0]                  command;
      logic [4:0]                  coef_index;
      logic signed [COORD_W-1:0]   coef_value;
      logic signed [COORD_W-1:0]   x_low;
      logic signed [COORD_W-1:0]   y_low;
      logic signed [COORD_W-1:0]   z_low;
      logic signed [COORD_W-1:0]   x_high;
      logic signed [COORD_W-1:0]   y_high;
      logic signed [COORD_W-1:0]   z_high;
      logic [RADIUS_W-1:0]         radius;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                  verdict;
      logic signed [COORD_W-1:0]   view_distance;
   } rsp_payload_type;

endpackage

FILE: hw/rtl/fcsb_if.sv
// ----------------------------------------------------------------------------
// fcsb_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface fcsb_req_if;
   logic                      valid;
   logic                      ready;
   fcsb_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fcsb_rsp_if;
   logic                      valid;
   logic                      ready;
   fcsb_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/frustum_cull_sphere_box.sv
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box
// Frustum culling of spheres and axis-aligned boxes against stored planes,
// one shared 32x32 multiplier stepping through every plane coefficient.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      contents
//  req_ch    in    valid/ready    command, coefficient write, sphere or box
//  rsp_ch    out   valid/ready    verdict, view_distance
//
//  In a sphere or box test the multiplier takes one coefficient per cycle,
//  behind a registered coefficient read and followed by an accumulate stage.
//  req_ch is ready only when no test is running; a result waiting on rsp_ch
//  does not block the next item, only the completion of the following test.
//  Reset is synchronous; the plane store is not cleared.
// ----------------------------------------------------------------------------
module frustum_cull_sphere_box #(
   parameter int PLANE_COUNT = 6,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   fcsb_req_if.sink    req_ch,
   fcsb_rsp_if.source  rsp_ch
);
   import fcsb_pkg::*;

   localparam int SLOT_COUNT = PLANE_COUNT * 4;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int PROD_W     = 2 * COORD_W;
   localparam int ACC_W      = PROD_W + 3;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
   localparam logic signed [COORD_W-1:0] ONE_FIX = COORD_W'(1) << FRAC_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic                       issue_ff, issue_in;
   logic [SLOT_W-1:0]          cnt_ff, cnt_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s2_valid_ff, s2_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic signed [COORD_W-1:0]  plane_mem [SLOT_COUNT];
   logic signed [COORD_W-1:0]  coef_ff;
   logic [SLOT_W-1:0]          s1_slot_ff;
   logic [SLOT_W-1:0]          s2_slot_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    dist_ff;
   logic                       outside_ff;
   logic                       above_ff;
   logic                       sphere_ff;
   logic [RADIUS_W-1:0]        radius_ff;
   logic signed [COORD_W-1:0]  x_hi_ff, x_lo_ff, y_hi_ff, y_lo_ff, z_hi_ff, z_lo_ff;
   logic [1:0]                 rsp_verdict_ff;
   logic signed [COORD_W-1:0]  rsp_dist_ff;

   logic                       req_fire;
   logic                       test_start;
   logic                       is_sphere;
   logic                       slot_ok;
   logic signed [COORD_W-1:0]  oper;
   logic signed [ACC_W-1:0]    r_scaled;
   logic signed [ACC_W-1:0]    psum;
   logic                       plane_out;
   logic                       plane_above;
   logic signed [ACC_W-1:0]    fin_sum;
   logic signed [ACC_W-1:0]    fin_shift;
   logic                       fin_fits;
   logic signed [COORD_W-1:0]  fin_dist;
   logic [1:0]                 fin_verdict;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_sphere    = (req_ch.data.command == CMD_SPHERE);
   assign test_start   = req_fire &&
                         (req_ch.data.command == CMD_SPHERE || req_ch.data.command == CMD_BOX);
   assign slot_ok      = ({1'b0, req_ch.data.coef_index} < 6'(SLOT_COUNT));

   // ---------------- control ----------------
   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      cnt_in       = cnt_ff;
      s1_valid_in  = issue_ff;
      s2_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (test_start) begin
               state_in = ST_RUN;
               issue_in = 1'b1;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (issue_ff) begin
               if (cnt_ff == LAST_SLOT) begin
                  issue_in = 1'b0;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            if (s2_valid_ff && s2_slot_ff == LAST_SLOT) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- plane store ----------------
   always_ff @(posedge clock) begin
      if (req_fire && req_ch.data.command == CMD_WRITE && slot_ok) begin
         plane_mem[req_ch.data.coef_index[SLOT_W-1:0]] <= req_ch.data.coef_value;
      end
      if (issue_ff) begin
         coef_ff <= plane_mem[cnt_ff];
      end
   end

   // ---------------- operand latch ----------------
   // Box: the corner farthest along the normal is the larger bound for a
   // non-negative coefficient and the smaller one otherwise.
   always_ff @(posedge clock) begin
      if (test_start) begin
         sphere_ff <= is_sphere;
         radius_ff <= is_sphere ? req_ch.data.radius : '0;
         if (is_sphere || req_ch.data.x_high >= req_ch.data.x_low) begin
            x_hi_ff <= is_sphere ? req_ch.data.x_low : req_ch.data.x_high;
            x_lo_ff <= req_ch.data.x_low;
         end else begin
            x_hi_ff <= req_ch.data.x_low;
            x_lo_ff <= req_ch.data.x_high;
         end
         if (is_sphere || req_ch.data.y_high >= req_ch.data.y_low) begin
            y_hi_ff <= is_sphere ? req_ch.data.y_low : req_ch.data.y_high;
            y_lo_ff <= req_ch.data.y_low;
         end else begin
            y_hi_ff <= req_ch.data.y_low;
            y_lo_ff <= req_ch.data.y_high;
         end
         if (is_sphere || req_ch.data.z_high >= req_ch.data.z_low) begin
            z_hi_ff <= is_sphere ? req_ch.data.z_low : req_ch.data.z_high;
            z_lo_ff <= req_ch.data.z_low;
         end else begin
            z_hi_ff <= req_ch.data.z_low;
            z_lo_ff <= req_ch.data.z_high;
         end
      end
   end

   // ---------------- multiply stage ----------------
   always_comb begin
      case (s1_slot_ff[1:0])
         COEF_A:  oper = coef_ff[COORD_W-1] ? x_lo_ff : x_hi_ff;
         COEF_B:  oper = coef_ff[COORD_W-1] ? y_lo_ff : y_hi_ff;
         COEF_C:  oper = coef_ff[COORD_W-1] ? z_lo_ff : z_hi_ff;
         default: oper = ONE_FIX;
      endcase
   end

   always_ff @(posedge clock) begin
      s1_slot_ff <= cnt_ff;
      if (s1_valid_ff) begin
         prod_ff    <= PROD_W'(coef_ff) * PROD_W'(oper);
         s2_slot_ff <= s1_slot_ff;
      end
   end

   // ---------------- accumulate and classify ----------------
   assign r_scaled    = ACC_W'(radius_ff) <<< FRAC_BITS;
   assign psum        = ((s2_slot_ff[1:0] == COEF_A) ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
   assign plane_out   = (psum <= -r_scaled);
   assign plane_above = (psum > r_scaled);

   always_ff @(posedge clock) begin
      if (test_start) begin
         outside_ff <= 1'b0;
         above_ff   <= 1'b1;
      end else if (s2_valid_ff) begin
         acc_ff <= psum;
         if (s2_slot_ff[1:0] == COEF_D) begin
            dist_ff    <= psum;
            outside_ff <= outside_ff || plane_out;
            above_ff   <= above_ff && plane_above;
         end
      end
   end

   // ---------------- result ----------------
   assign fin_sum   = dist_ff + r_scaled;
   assign fin_shift = fin_sum >>> FRAC_BITS;
   assign fin_fits  = (&fin_shift[ACC_W-1:COORD_W-1]) || !(|fin_shift[ACC_W-1:COORD_W-1]);

   always_comb begin
      if (!sphere_ff || outside_ff) begin
         fin_dist = '0;
      end else if (fin_fits) begin
         fin_dist = fin_shift[COORD_W-1:0];
      end else if (fin_shift[ACC_W-1]) begin
         fin_dist = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         fin_dist = {1'b0, {(COORD_W-1){1'b1}}};
      end
      if (outside_ff) begin
         fin_verdict = sphere_ff ? VERDICT_OUTSIDE : VERDICT_CULLED;
      end else if (!sphere_ff) begin
         fin_verdict = VERDICT_VISIBLE;
      end else begin
         fin_verdict = above_ff ? VERDICT_INSIDE : VERDICT_PARTLY;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_verdict_ff <= fin_verdict;
         rsp_dist_ff    <= fin_dist;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.data.verdict       = rsp_verdict_ff;
   assign rsp_ch.data.view_distance = rsp_dist_ff;

endmodule

FILE: hw/rtl/fcsb_checker.sv
// ----------------------------------------------------------------------------
// fcsb_checker
// Port-level checks for the frustum culling block, bound to its top level.
// ----------------------------------------------------------------------------
module fcsb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_verdict,
   input  logic [31:0] rsp_view_distance
);
   import fcsb_pkg::*;

   // a result held under back-pressure keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) &&
                                  $stable(rsp_view_distance))
      else $error("result changed while stalled");

   // a coefficient write never makes a result appear
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("coefficient write produced a result");

   // a test keeps the request side closed while it runs
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_SPHERE || req_command == CMD_BOX)
      |=> !req_ready)
      else $error("request accepted while a test is running");

   // an outside or culled result carries no distance
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_OUTSIDE |-> rsp_view_distance == 32'd0)
      else $error("outside result with nonzero distance");

endmodule

bind frustum_cull_sphere_box fcsb_checker u_fcsb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_command       (req_ch.data.command),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_verdict       (rsp_ch.data.verdict),
   .rsp_view_distance (rsp_ch.data.view_distance)
);

FILE: tb/cull_result_checker.sv
// ----------------------------------------------------------------------------
// cull_result_checker
// Watches the request and result channels of the frustum culling block,
// keeps its own copy of the plane coefficients, predicts the verdict and
// view distance of every sphere and box test, and compares each result in
// order against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cull_result_checker #(
   parameter int PLANE_COUNT = 6,
   parameter int FRAC_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  fcsb_pkg::req_payload_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  fcsb_pkg::rsp_payload_type rsp_data,
   output int                        mismatch_count,
   output int                        results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import fcsb_pkg::*;

   localparam int SLOT_COUNT = 4 * PLANE_COUNT;

   // wide enough for three full 32x32 products plus the scaled offset
   typedef logic signed [71:0] exact_type;

   logic signed [COORD_W-1:0] plane_coefs [SLOT_COUNT];
   rsp_payload_type           expected_verdicts [$];
   int                        result_index;

   function automatic exact_type widen(logic signed [COORD_W-1:0] v);
      exact_type w;
      w = exact_type'(v);
      return w;
   endfunction

   function automatic exact_type plane_distance(int p, logic signed [COORD_W-1:0] x,
                                                logic signed [COORD_W-1:0] y,
                                                logic signed [COORD_W-1:0] z);
      return widen(plane_coefs[4*p + COEF_A]) * widen(x)
           + widen(plane_coefs[4*p + COEF_B]) * widen(y)
           + widen(plane_coefs[4*p + COEF_C]) * widen(z)
           + (widen(plane_coefs[4*p + COEF_D]) <<< FRAC_BITS);
   endfunction

   // larger of the two extreme products along one axis
   function automatic exact_type farthest_term(logic signed [COORD_W-1:0] coef,
                                               logic signed [COORD_W-1:0] lo,
                                               logic signed [COORD_W-1:0] hi);
      exact_type p, q;
      p = widen(coef) * widen(lo);
      q = widen(coef) * widen(hi);
      return (p > q) ? p : q;
   endfunction

   function automatic rsp_payload_type predict_cull(req_payload_type item);
      rsp_payload_type res;
      exact_type       reach, plane_gap, total, scaled_back;
      int              clear_planes;
      res.verdict       = VERDICT_VISIBLE;
      res.view_distance = '0;
      if (item.command == CMD_BOX) begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            total = farthest_term(plane_coefs[4*p + COEF_A], item.x_low, item.x_high)
                  + farthest_term(plane_coefs[4*p + COEF_B], item.y_low, item.y_high)
                  + farthest_term(plane_coefs[4*p + COEF_C], item.z_low, item.z_high)
                  + (widen(plane_coefs[4*p + COEF_D]) <<< FRAC_BITS);
            if (total <= 0) begin
               res.verdict = VERDICT_CULLED;
               break;
            end
         end
         return res;
      end
      reach = '0;
      reach[RADIUS_W-1+FRAC_BITS:FRAC_BITS] = item.radius;
      plane_gap = '0;
      clear_planes = 0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         plane_gap = plane_distance(p, item.x_low, item.y_low, item.z_low);
         if (plane_gap <= -reach) begin
            res.verdict = VERDICT_OUTSIDE;
            return res;
         end
         if (plane_gap > reach) clear_planes++;
      end
      res.verdict = (clear_planes == PLANE_COUNT) ? VERDICT_INSIDE : VERDICT_PARTLY;
      // last plane's distance plus radius, floored back to Q16.16 and clamped
      scaled_back = (plane_gap + reach) >>> FRAC_BITS;
      if (scaled_back > widen(32'sh7FFFFFFF))
         res.view_distance = 32'sh7FFFFFFF;
      else if (scaled_back < widen(32'sh80000000))
         res.view_distance = 32'sh80000000;
      else
         res.view_distance = scaled_back[COORD_W-1:0];
      return res;
   endfunction

   task automatic flag_error(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0t] result %0d: %s", $realtime, result_index, msg);
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         expected_verdicts.delete();
      end else begin
         // a result can never belong to the item taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               flag_error($sformatf("unexpected result verdict %0d distance %0d",
                                    rsp_data.verdict, rsp_data.view_distance));
            end else begin
               want = expected_verdicts.pop_front();
               if (want.verdict !== rsp_data.verdict)
                  flag_error($sformatf("verdict expected %0d, got %0d",
                                       want.verdict, rsp_data.verdict));
               if (want.view_distance !== rsp_data.view_distance)
                  flag_error($sformatf("view_distance expected %0d, got %0d",
                                       want.view_distance, rsp_data.view_distance));
            end
            result_index++;
         end
         if (req_valid && req_ready) begin
            case (req_data.command)
               CMD_WRITE: begin
                  if (req_data.coef_index < SLOT_COUNT)
                     plane_coefs[req_data.coef_index] = req_data.coef_value;
               end
               CMD_SPHERE, CMD_BOX: begin
                  expected_verdicts.push_back(predict_cull(req_data));
               end
               default: ;
            endcase
         end
      end
      results_pending = expected_verdicts.size();
   end

endmodule

FILE: tb/frustum_cull_sphere_box_tb.sv
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box_tb
// Drives coefficient loads, sphere tests and box tests into the frustum
// culling block with random gaps and result stalls, including a long result
// hold-off, and reports the verdict of the attached result checker.
// ----------------------------------------------------------------------------
module frustum_cull_sphere_box_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fcsb_pkg::*;

   localparam int PLANE_COUNT  = 6;
   localparam int FRAC_BITS    = 16;
   localparam int SLOT_COUNT   = 4 * PLANE_COUNT;
   localparam int UNIT         = 1 << FRAC_BITS;
   localparam int COORD_MAX    = 32'sh7FFFFFFF;
   localparam int COORD_MIN    = 32'sh80000000;
   localparam int RADIUS_MAX   = 32'h7FFFFFFF;
   localparam int ITEM_TARGET  = 1450;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 4 * PLANE_COUNT + 3 + 20;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum {FRAME_CUBE, FRAME_SKEW, FRAME_WILD} frame_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fcsb_req_if req_ch ();
   fcsb_rsp_if rsp_ch ();

   int mismatch_count;
   int results_pending;
   int cycle_count;
   int counted_items;
   int offered_items;
   bit source_quiet;
   bit hold_results;

   // current plane set and the region its tests are drawn from
   frame_kind_type frame_kind;
   int             frame_half;
   int             frame_center [3];
   int             frame_coefs [SLOT_COUNT];

   frustum_cull_sphere_box #(
      .PLANE_COUNT (PLANE_COUNT),
      .FRAC_BITS   (FRAC_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cull_result_checker #(
      .PLANE_COUNT (PLANE_COUNT),
      .FRAC_BITS   (FRAC_BITS)
   ) verdict_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_data        (req_ch.data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_data        (rsp_ch.data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("frustum_cull_sphere_box verification failed");
         $finish;
      end
   end

   function automatic int rand_span(int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   function automatic int wild_value();
      case ($urandom_range(0, 7))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         default: return $urandom();
      endcase
   endfunction

   function automatic int pick_coord(int axis);
      case (frame_kind)
         FRAME_CUBE: return frame_center[axis] + rand_span(frame_half + frame_half / 2);
         FRAME_SKEW: return rand_span(1 << 27);
         default:    return wild_value();
      endcase
   endfunction

   function automatic int pick_radius();
      case (frame_kind)
         FRAME_CUBE: begin
            if ($urandom_range(0, 2) == 0) return $urandom_range(0, frame_half / 16);
            return $urandom_range(0, frame_half);
         end
         FRAME_SKEW: return $urandom_range(0, 1 << 30);
         default:    return ($urandom_range(0, 7) == 0) ? RADIUS_MAX : $urandom() & RADIUS_MAX;
      endcase
   endfunction

   function automatic int pick_coef();
      case (frame_kind)
         FRAME_CUBE: return rand_span(1 << 17);
         FRAME_SKEW: return rand_span(1 << 20);
         default:    return wild_value();
      endcase
   endfunction

   // every field random, so unused fields toggle too
   function automatic req_payload_type random_item(logic [1:0] cmd);
      req_payload_type it;
      it.command    = cmd;
      it.coef_index = 5'($urandom_range(0, 31));
      it.coef_value = $urandom();
      it.x_low      = $urandom();
      it.y_low      = $urandom();
      it.z_low      = $urandom();
      it.x_high     = $urandom();
      it.y_high     = $urandom();
      it.z_high     = $urandom();
      it.radius     = RADIUS_W'($urandom());
      return it;
   endfunction

   // axis-aligned cube planes (normals +-1 with optional tilt), or random sets
   function automatic void build_frame(frame_kind_type kind, int half, bit jitter);
      int axis, sgn;
      frame_kind = kind;
      frame_half = half;
      for (int k = 0; k < 3; k++) frame_center[k] = jitter ? rand_span(half / 2) : 0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         axis = (p / 2) % 3;
         sgn  = (p % 2) ? -1 : 1;
         for (int k = 0; k < 3; k++) begin
            case (kind)
               FRAME_CUBE: begin
                  if (k == axis) frame_coefs[4*p + k] = sgn * UNIT + (jitter ? rand_span(4096) : 0);
                  else           frame_coefs[4*p + k] = jitter ? rand_span(8192) : 0;
               end
               FRAME_SKEW: frame_coefs[4*p + k] = rand_span(1 << 20);
               default:    frame_coefs[4*p + k] = wild_value();
            endcase
         end
         case (kind)
            FRAME_CUBE: frame_coefs[4*p + COEF_D] = half - sgn * frame_center[axis];
            FRAME_SKEW: frame_coefs[4*p + COEF_D] = $urandom();
            default:    frame_coefs[4*p + COEF_D] = wild_value();
         endcase
      end
   endfunction

   task automatic offer_item(req_payload_type item);
      int gap;
      gap = source_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= item;
      do @(posedge clock); while (!req_ch.ready);
      if (!(item.command == CMD_UNUSED ||
            (item.command == CMD_WRITE && item.coef_index >= SLOT_COUNT)))
         counted_items++;
      offered_items++;
      if (offered_items % 48 == 0) source_quiet = ($urandom_range(0, 3) == 0);
   endtask

   task automatic write_coef(int slot, int value);
      req_payload_type it;
      it = random_item(CMD_WRITE);
      it.coef_index = 5'(slot);
      it.coef_value = value;
      offer_item(it);
   endtask

   task automatic sphere_test(int x, int y, int z, int r);
      req_payload_type it;
      it = random_item(CMD_SPHERE);
      it.x_low  = x;
      it.y_low  = y;
      it.z_low  = z;
      it.radius = RADIUS_W'(r);
      offer_item(it);
   endtask

   task automatic box_test(int xl, int yl, int zl, int xh, int yh, int zh);
      req_payload_type it;
      it = random_item(CMD_BOX);
      it.x_low  = xl;
      it.y_low  = yl;
      it.z_low  = zl;
      it.x_high = xh;
      it.y_high = yh;
      it.z_high = zh;
      offer_item(it);
   endtask

   // loads the whole set, starting at a random slot, with ignored items mixed in
   task automatic store_frame();
      int start, slot;
      start = $urandom_range(0, SLOT_COUNT - 1);
      for (int k = 0; k < SLOT_COUNT; k++) begin
         slot = (start + k) % SLOT_COUNT;
         write_coef(slot, frame_coefs[slot]);
         if ($urandom_range(0, 15) == 0) begin
            if ($urandom_range(0, 1) == 0) offer_item(random_item(CMD_UNUSED));
            else write_coef($urandom_range(SLOT_COUNT, 31), $urandom());
         end
      end
   endtask

   // result side: random stalls per item, plus one long hold when asked
   initial begin : result_sink
      int stall, taken;
      bit sink_quiet;
      taken = 0;
      sink_quiet = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_results) begin
            stall = HOLD_CYCLES;
            hold_results = 1'b0;
         end else begin
            stall = sink_quiet ? 0 : $urandom_range(0, 11);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
         if (taken % 40 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin : stimulus
      int round, pick, span;
      int lo [3];
      int hi [3];
      int tmp;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // exact cube of half extent 100.0 around the origin
      build_frame(FRAME_CUBE, 100 * UNIT, 1'b0);
      store_frame();
      span = 100 * UNIT;
      sphere_test(0, 0, 0, UNIT);
      sphere_test(0, 0, 0, 0);
      sphere_test(span, 0, 0, 0);                  // center on a plane, no radius
      sphere_test(span + UNIT, 0, 0, UNIT);        // distance equals minus radius
      sphere_test(span + UNIT - 1, 0, 0, UNIT);    // one step back in
      sphere_test(span - UNIT, 0, 0, UNIT);        // distance equals radius
      sphere_test(0, 0, 0, RADIUS_MAX);
      sphere_test(COORD_MAX, COORD_MIN, COORD_MAX, RADIUS_MAX);
      box_test(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT);
      box_test(span + UNIT, 0, 0, span + 2 * UNIT, UNIT, UNIT);
      box_test(span - UNIT, 0, 0, span + UNIT, UNIT, UNIT);
      box_test(span, 0, 0, span + UNIT, UNIT, UNIT);   // touching from outside
      box_test(UNIT, UNIT, UNIT, -UNIT, -UNIT, -UNIT); // inverted, inside
      box_test(span + 2 * UNIT, 0, 0, span + UNIT, UNIT, UNIT);
      box_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      offer_item(random_item(CMD_UNUSED));
      write_coef(SLOT_COUNT, COORD_MIN);
      write_coef(31, COORD_MAX);
      sphere_test(0, 0, 0, UNIT);

      // extreme coefficients: saturated distance and full-range products
      for (int k = 0; k < SLOT_COUNT; k++) write_coef(k, COORD_MAX);
      sphere_test(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
      box_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      for (int k = 0; k < SLOT_COUNT; k++) write_coef(k, COORD_MIN);
      sphere_test(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
      sphere_test(COORD_MIN, COORD_MIN, COORD_MIN, 0);
      box_test(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      box_test(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);

      round = 0;
      while (counted_items < ITEM_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick < 14)      build_frame(FRAME_CUBE, $urandom_range(UNIT, 1 << 24), 1'b1);
         else if (pick < 17) build_frame(FRAME_SKEW, 0, 1'b1);
         else                build_frame(FRAME_WILD, 0, 1'b1);
         store_frame();
         if (round == 2 || round == 11) hold_results = 1'b1;
         repeat ($urandom_range(20, 60)) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               sphere_test(pick_coord(0), pick_coord(1), pick_coord(2), pick_radius());
            end else if (pick < 90) begin
               for (int k = 0; k < 3; k++) begin
                  lo[k] = pick_coord(k);
                  if (frame_kind == FRAME_CUBE) begin
                     hi[k] = lo[k] + $urandom_range(0, frame_half / 2);
                     if ($urandom_range(0, 9) == 0) begin
                        tmp   = lo[k];
                        lo[k] = hi[k];
                        hi[k] = tmp;
                     end
                  end else begin
                     hi[k] = pick_coord(k);
                  end
               end
               box_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
            end else if (pick < 95) begin
               write_coef($urandom_range(0, 31), pick_coef());
            end else begin
               offer_item(random_item(CMD_UNUSED));
            end
         end
         round++;
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("frustum_cull_sphere_box verification clean");
      else
         $display("frustum_cull_sphere_box verification failed");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/fcsb_pkg.sv
hw/rtl/fcsb_if.sv
hw/rtl/frustum_cull_sphere_box.sv
hw/rtl/fcsb_checker.sv
tb/cull_result_checker.sv
tb/frustum_cull_sphere_box_tb.sv
